### sv/dshot_enc_pkg.sv
package dshot_enc_pkg;

  // Frame layout and fixed field widths.
  localparam int FRAME_BITS   = 16;
  localparam int BIT_IDX_W    = 4;
  localparam int LEVEL_W      = 28;
  localparam int PIN_W        = 5;
  localparam int THROTTLE_W   = 11;
  localparam int CMD_W        = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int NUM_PINS_DEF = 28;

  // Configuration reset values.
  localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST = 8'd32;
  localparam logic [CFG_DATA_W-1:0] ZERO_HIGH_RST  = 8'd12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 1'b1;

  // Input commands. The remaining code is ignored.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_DISABLE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  // Builds a DShot frame: throttle, telemetry bit, then XOR of the three nibbles.
  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [THROTTLE_W-1:0] throttle,
    input logic                  telemetry
  );
    logic [11:0] v;
    logic [3:0]  crc;
    v   = {throttle, telemetry};
    crc = v[3:0] ^ v[7:4] ^ v[11:8];
    return {v, crc};
  endfunction

endpackage

### sv/dshot_multi_pin_waveform_encoder.sv
// A tick transaction's slot is registered and shown on the output in the cycle after it is accepted.
// Throughput: one transaction per cycle; set and disable are taken even while a slot
// result waits, a tick waits only while the output register is full and not drained.
// The per-pin levels are one compare per pin against the shared bit and slot counters.
// Reset (rst_n low, synchronous) clears all pins to inactive, restarts the frame at its
// top bit, and loads bit_period = 32 and zero_high = 12.
module dshot_multi_pin_waveform_encoder #(
  parameter int NUM_PINS = dshot_enc_pkg::NUM_PINS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dshot_enc_pkg::CMD_W-1:0]      in_command,
  input  logic [dshot_enc_pkg::PIN_W-1:0]      in_pin,
  input  logic [dshot_enc_pkg::THROTTLE_W-1:0] in_throttle,
  input  logic                                 in_telemetry,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dshot_enc_pkg::LEVEL_W-1:0]    out_pin_levels,
  output logic                                 out_frame_end,
  input  logic                                 cfg_we,
  input  logic [dshot_enc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dshot_enc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dshot_enc_pkg::*;

  logic [CFG_DATA_W-1:0] bit_period_r;
  logic [CFG_DATA_W-1:0] zero_high_r;
  logic [FRAME_BITS-1:0] frame_r [NUM_PINS];
  logic [NUM_PINS-1:0]   active_r;
  logic [BIT_IDX_W-1:0]  bit_idx_r;
  logic [BIT_IDX_W-1:0]  bit_idx_nxt;
  logic [7:0]            slot_r;
  logic [7:0]            slot_nxt;
  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    out_levels_r;
  logic                  out_frame_end_r;

  logic                  is_tick;
  logic                  is_write;
  logic                  tick_acc;
  logic                  write_acc;
  logic [FRAME_BITS-1:0] new_frame;
  logic [7:0]            period;
  logic [8:0]            zh2;
  logic [7:0]            t0;
  logic [7:0]            t1;
  logic                  last_slot;
  logic [LEVEL_W-1:0]    lane_level;
  logic [LEVEL_W-1:0]    active_mask;

  // Command decode and handshake: only a tick needs room in the output register.
  assign is_tick   = (in_command == CMD_TICK);
  assign is_write  = (in_command == CMD_SET) || (in_command == CMD_DISABLE);
  assign in_ready  = !is_tick || !out_valid_r || out_ready;
  assign tick_acc  = in_valid && in_ready && is_tick;
  assign write_acc = in_valid && in_ready && is_write;
  assign new_frame = (in_command == CMD_SET) ? build_frame(in_throttle, in_telemetry)
                                             : '0;

  // Pulse widths for this slot, both saturated at the bit period.
  always_comb begin
    period    = (bit_period_r == '0) ? 8'd1 : bit_period_r;
    zh2       = {zero_high_r, 1'b0};
    t0        = (zero_high_r < period) ? zero_high_r : period;
    t1        = (zh2 < {1'b0, period}) ? zh2[7:0] : period;
    last_slot = (({1'b0, slot_r} + 9'd1) >= {1'b0, period});
  end

  // One level per visible pin.
  for (genvar n = 0; n < LEVEL_W; n++) begin : g_lane
    if (n < NUM_PINS) begin : g_on
      assign lane_level[n]  = active_r[n] &&
                              (slot_r < (frame_r[n][bit_idx_r] ? t1 : t0));
      assign active_mask[n] = active_r[n];
    end else begin : g_off
      assign lane_level[n]  = 1'b0;
      assign active_mask[n] = 1'b0;
    end
  end

  // Shared bit and slot position.
  always_comb begin
    if (last_slot) begin
      slot_nxt    = '0;
      bit_idx_nxt = (bit_idx_r == '0) ? BIT_IDX_W'(FRAME_BITS - 1) : bit_idx_r - 1'b1;
    end else begin
      slot_nxt    = slot_r + 8'd1;
      bit_idx_nxt = bit_idx_r;
    end
  end

  // Frame words carry no reset: a pin's word is only read once the pin is active.
  always_ff @(posedge clk) begin
    for (int n = 0; n < NUM_PINS; n++) begin
      if (write_acc && (32'(in_pin) == n)) begin
        frame_r[n] <= new_frame;
      end
    end
  end

  // Control state, configuration and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
      zero_high_r  <= ZERO_HIGH_RST;
      active_r     <= '0;
      bit_idx_r    <= BIT_IDX_W'(FRAME_BITS - 1);
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BIT_PERIOD: bit_period_r <= cfg_wdata;
          REG_ZERO_HIGH:  zero_high_r  <= cfg_wdata;
          default: ;
        endcase
      end
      for (int n = 0; n < NUM_PINS; n++) begin
        if (write_acc && (32'(in_pin) == n)) begin
          active_r[n] <= 1'b1;
        end
      end
      if (tick_acc) begin
        slot_r      <= slot_nxt;
        bit_idx_r   <= bit_idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot payload.
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_levels_r    <= lane_level;
      out_frame_end_r <= last_slot && (bit_idx_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_levels_r;
  assign out_frame_end  = out_frame_end_r;

`ifndef SYNTHESIS
  // A pending end-of-frame slot means the counters have wrapped to a new frame.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> (bit_idx_r == BIT_IDX_W'(FRAME_BITS - 1)) &&
                                       (slot_r == '0))
    else $error("frame_end shown without counter wrap");

  // The slot counter moves only on an accepted tick.
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_acc |=> $stable(slot_r) && $stable(bit_idx_r))
    else $error("slot position moved without a tick");

  // Pins that were never set or disabled stay low.
  a_inactive_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_levels_r & ~active_mask) == '0))
    else $error("inactive pin driven high");

  // A stalled slot result is not overwritten by a new tick.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !tick_acc)
    else $error("tick accepted over a pending slot");
`endif

endmodule
